// File: sv/two_pkg.sv
// shared types, constants and tables for the tracking wheel odometry block
package two_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int DIV_W        = 64;
    localparam int DIV_CNT_W    = $clog2(DIV_W);
    localparam int RED_STEPS    = 6;

    localparam logic [32:0]        Q_TWO_PI_U  = 33'd105414357;
    localparam logic signed [28:0] Q_PI        = 29'sd52707179;
    localparam logic signed [28:0] Q_HALF_PI   = 29'sd26353589;
    localparam logic signed [28:0] Q_TWO_PI    = 29'sd105414357;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [32:0] DEG_TO_RAD  = 33'sd74961321;

    typedef enum logic [2:0] {
        CFG_LR_TPI,
        CFG_MID_TPI,
        CFG_TRACK_W,
        CFG_MID_OFF,
        CFG_SENSOR
    } t_cfg_idx;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] middle_count;
        logic signed [31:0] imu_rotation;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_theta;
        logic               theta_given;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_theta;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [31:0]       den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic               start;
        logic signed [32:0] angle;
    } t_cor_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_cor_rsp;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SET, ST_DL, ST_DR, ST_DM, ST_HEAD, ST_IMU, ST_STR,
        ST_CA, ST_M1, ST_D1, ST_M2, ST_M2U, ST_M3, ST_D2, ST_M4, ST_M4U,
        ST_CP, ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        COR_IDLE, COR_RED, COR_FOLD, COR_ROT
    } t_cor_state;

    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        case (k)
            5'd0:  return 32'd843314856;
            5'd1:  return 32'd497837829;
            5'd2:  return 32'd263043836;
            5'd3:  return 32'd133525158;
            5'd4:  return 32'd67021686;
            5'd5:  return 32'd33543515;
            5'd6:  return 32'd16775850;
            5'd7:  return 32'd8388437;
            5'd8:  return 32'd4194282;
            5'd9:  return 32'd2097149;
            5'd10: return 32'd1048575;
            5'd11: return 32'd524287;
            5'd12: return 32'd262143;
            5'd13: return 32'd131071;
            5'd14: return 32'd65535;
            5'd15: return 32'd32767;
            5'd16: return 32'd16383;
            5'd17: return 32'd8191;
            5'd18: return 32'd4095;
            5'd19: return 32'd2047;
            5'd20: return 32'd1023;
            5'd21: return 32'd511;
            5'd22: return 32'd255;
            5'd23: return 32'd127;
            5'd24: return 32'd63;
            5'd25: return 32'd31;
            5'd26: return 32'd15;
            5'd27: return 32'd8;
            5'd28: return 32'd4;
            5'd29: return 32'd2;
            5'd30: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// File: sv/two_div.sv
// serial restoring divider, one quotient bit per cycle
module two_div import two_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [31:0]          r_rem;
    logic [31:0]          r_den;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_sub;
    logic                 take;

    always_comb begin
        rem_sh  = {r_rem, r_num[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        take    = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[31:0] : rem_sh[31:0];
            r_num <= {r_num[DIV_W-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = (r_den == 32'd0) ? '0 : r_num;

endmodule

// File: sv/two_cordic.sv
// iterative cordic sine and cosine with range reduction
module two_cordic import two_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cor_req i_req,
    output t_cor_rsp o_rsp
);

    t_cor_state         r_st,   n_st;
    logic               r_done, n_done;
    logic [4:0]         r_k,    n_k;
    logic [32:0]        r_mag,  n_mag;
    logic               r_sgn,  n_sgn;
    logic               r_flip, n_flip;
    logic signed [33:0] r_x,    n_x;
    logic signed [33:0] r_y,    n_y;
    logic signed [33:0] r_z,    n_z;

    logic [32:0]        tw_sh;
    logic signed [28:0] rr, r1, r2;
    logic               fl;
    logic signed [33:0] sh_x, sh_y, at;
    logic signed [33:0] c_r, s_r;

    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        n_k    = r_k;
        n_mag  = r_mag;
        n_sgn  = r_sgn;
        n_flip = r_flip;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        tw_sh  = Q_TWO_PI_U << r_k;
        rr     = r_sgn ? -$signed({1'b0, r_mag[27:0]}) : $signed({1'b0, r_mag[27:0]});
        r1     = rr;
        if (rr > Q_PI) begin
            r1 = rr - Q_TWO_PI;
        end else if (rr < -Q_PI) begin
            r1 = rr + Q_TWO_PI;
        end
        r2 = r1;
        fl = 1'b0;
        if (r1 > Q_HALF_PI) begin
            r2 = r1 - Q_PI;
            fl = 1'b1;
        end else if (r1 < -Q_HALF_PI) begin
            r2 = r1 + Q_PI;
            fl = 1'b1;
        end
        sh_x = r_x >>> r_k;
        sh_y = r_y >>> r_k;
        at   = $signed({2'b00, atan_q30(r_k)});
        case (r_st)
            COR_IDLE: begin
                if (i_req.start) begin
                    n_sgn = i_req.angle[32];
                    n_mag = i_req.angle[32] ? 33'(-i_req.angle) : i_req.angle;
                    n_k   = 5'(RED_STEPS - 1);
                    n_st  = COR_RED;
                end
            end
            COR_RED: begin
                if (r_mag >= tw_sh) begin
                    n_mag = r_mag - tw_sh;
                end
                n_k = r_k - 1'b1;
                if (r_k == 5'd0) begin
                    n_st = COR_FOLD;
                end
            end
            COR_FOLD: begin
                n_flip = fl;
                n_z    = $signed({{5{r2[28]}}, r2}) <<< 6;
                n_x    = CORDIC_GAIN;
                n_y    = '0;
                n_k    = '0;
                n_st   = COR_ROT;
            end
            COR_ROT: begin
                if (r_z >= 0) begin
                    n_x = r_x - sh_y;
                    n_y = r_y + sh_x;
                    n_z = r_z - at;
                end else begin
                    n_x = r_x + sh_y;
                    n_y = r_y - sh_x;
                    n_z = r_z + at;
                end
                n_k = r_k + 1'b1;
                if (r_k == 5'(CORDIC_STEPS - 1)) begin
                    n_st   = COR_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_st = COR_IDLE;
        endcase
        c_r = (r_x + 34'sd32) >>> 6;
        s_r = (r_y + 34'sd32) >>> 6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= COR_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_mag  <= n_mag;
        r_sgn  <= n_sgn;
        r_flip <= n_flip;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.c    = r_flip ? 32'(-c_r) : 32'(c_r);
    assign o_rsp.s    = r_flip ? 32'(-s_r) : 32'(s_r);

endmodule

// File: sv/tracking_wheel_odometry_top.sv
// top level: odometry sequencer with shared multiplier, divider and cordic
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// set pose uses neither the divider nor the cordic; an update runs three serial divider
// passes with the imu, four on a straight wheel move and six on an arc, and one cordic
// pass, or two on an arc.
// synchronous active-low reset restores the register defaults and zero pose.
// ready is high only while idle; a result waits in the output register until taken.
module tracking_wheel_odometry_top import two_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [30:0] r_lr_tpi, r_mid_tpi, r_track_w;
    logic signed [31:0] r_mid_off;
    logic [3:0]  r_sensor;

    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic   r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    t_in_item  r_in, n_in;
    logic [31:0] r_prev_l, n_prev_l, r_prev_r, n_prev_r, r_prev_m, n_prev_m;
    logic signed [31:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y, r_heading, n_heading;
    logic signed [31:0] r_dl, n_dl, r_dr, n_dr, r_dm, n_dm, r_da, n_da;
    logic signed [31:0] r_lx, n_lx, r_ly, n_ly, r_s, n_s, r_c, n_c;
    logic signed [32:0] r_i, n_i;
    logic signed [65:0] r_acc, n_acc, r_prod, n_prod;
    logic   r_qneg, n_qneg;

    logic signed [32:0] mul_a, mul_b;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_cor_req cor_req;
    t_cor_rsp cor_rsp;

    logic [31:0] d_l, d_r, d_m;
    logic signed [32:0] dd;
    logic [32:0] dd_mag;
    logic signed [65:0] q_s, prod_abs, prod_r, xd, yd, rad;
    logic signed [31:0] da_half;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] sat_dist(input logic neg, input logic [63:0] q);
        if (neg) begin
            return (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        end
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > $signed(66'h0_7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < $signed({{34{1'b1}}, 32'h8000_0000})) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] rnd24(input logic signed [65:0] v);
        return (v + 66'sd8388608) >>> 24;
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        return $signed({{34{v[31]}}, v});
    endfunction

    two_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    two_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    always_comb begin
        d_l      = r_in.left_count - r_prev_l;
        d_r      = r_in.right_count - r_prev_r;
        d_m      = r_in.middle_count - r_prev_m;
        dd       = $signed({r_dr[31], r_dr}) - $signed({r_dl[31], r_dl});
        dd_mag   = dd[32] ? 33'(-dd) : 33'(dd);
        q_s      = r_qneg ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
        prod_abs = r_prod[65] ? -r_prod : r_prod;
        prod_r   = rnd24(r_prod);
        xd       = rnd24(r_acc - r_prod);
        yd       = rnd24(r_acc + r_prod);
        rad      = sx66(sat32(rnd24(r_prod)));
        da_half  = r_da >>> 1;
    end

    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_in        = r_in;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_prev_m    = r_prev_m;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_dl        = r_dl;
        n_dr        = r_dr;
        n_dm        = r_dm;
        n_da        = r_da;
        n_lx        = r_lx;
        n_ly        = r_ly;
        n_s         = r_s;
        n_c         = r_c;
        n_i         = r_i;
        n_acc       = r_acc;
        n_qneg      = r_qneg;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        cor_req     = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = i_in_data.opcode ? ST_SET : ST_DL;
                end
            end
            ST_SET: begin
                n_pos_x = r_in.new_x;
                n_pos_y = r_in.new_y;
                if (r_in.theta_given) begin
                    n_heading = r_in.new_theta;
                end
                n_state = ST_DONE;
            end
            ST_DL: begin
                div_req.start = !r_wait;
                div_req.num   = {mag32(d_l), 32'd0};
                div_req.den   = {1'b0, r_lr_tpi};
                n_wait        = 1'b1;
                if (div_rsp.done) begin
                    n_wait   = 1'b0;
                    n_dl     = r_sensor[0] ? sat_dist(d_l[31], div_rsp.quo) : '0;
                    n_prev_l = r_sensor[0] ? r_in.left_count : '0;
                    n_state  = ST_DR;
                end
            end
            ST_DR: begin
                div_req.start = !r_wait;
                div_req.num   = {mag32(d_r), 32'd0};
                div_req.den   = {1'b0, r_lr_tpi};
                n_wait        = 1'b1;
                if (div_rsp.done) begin
                    n_wait   = 1'b0;
                    n_dr     = r_sensor[1] ? sat_dist(d_r[31], div_rsp.quo) : '0;
                    n_prev_r = r_sensor[1] ? r_in.right_count : '0;
                    n_state  = ST_DM;
                end
            end
            ST_DM: begin
                div_req.start = !r_wait;
                div_req.num   = {mag32(d_m), 32'd0};
                div_req.den   = {1'b0, r_mid_tpi};
                n_wait        = 1'b1;
                if (div_rsp.done) begin
                    n_wait   = 1'b0;
                    n_dm     = r_sensor[2] ? sat_dist(d_m[31], div_rsp.quo) : '0;
                    n_prev_m = r_sensor[2] ? r_in.middle_count : '0;
                    n_state  = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (r_sensor[3]) begin
                    mul_a   = $signed({r_in.imu_rotation[31], r_in.imu_rotation});
                    mul_b   = DEG_TO_RAD;
                    n_state = ST_IMU;
                end else begin
                    div_req.start = !r_wait;
                    div_req.num   = {7'd0, dd_mag, 24'd0};
                    div_req.den   = {1'b0, r_track_w};
                    n_qneg        = dd[32];
                    n_wait        = 1'b1;
                    if (div_rsp.done) begin
                        n_wait    = 1'b0;
                        n_da      = sat32(q_s);
                        n_heading = sat32(sx66(r_heading) + sx66(sat32(q_s)));
                        n_state   = (sat32(q_s) != 32'sd0) ? ST_CA : ST_STR;
                    end
                end
            end
            ST_IMU: begin
                n_heading = sat32(-rad);
                n_da      = '0;
                n_state   = ST_STR;
            end
            ST_STR: begin
                n_lx    = r_dr;
                n_ly    = r_dm;
                n_state = ST_CP;
            end
            ST_CA: begin
                cor_req.start = !r_wait;
                cor_req.angle = $signed({da_half[31], da_half});
                n_wait        = 1'b1;
                if (cor_rsp.done) begin
                    n_wait  = 1'b0;
                    n_i     = $signed({cor_rsp.s, 1'b0});
                    n_state = ST_M1;
                end
            end
            ST_M1: begin
                mul_a   = $signed({r_dr[31], r_dr});
                mul_b   = r_i;
                n_state = ST_D1;
            end
            ST_D1, ST_D2: begin
                div_req.start = !r_wait;
                div_req.num   = prod_abs[63:0];
                div_req.den   = mag32(r_da);
                if (!r_wait) begin
                    n_qneg = r_prod[65] ^ r_da[31];
                end
                n_wait = 1'b1;
                if (div_rsp.done) begin
                    n_wait  = 1'b0;
                    n_acc   = q_s;
                    n_state = (r_state == ST_D1) ? ST_M2 : ST_M4;
                end
            end
            ST_M2: begin
                mul_a   = $signed({3'b000, r_track_w[30:1]});
                mul_b   = r_i;
                n_state = ST_M2U;
            end
            ST_M2U: begin
                n_lx    = sat32(r_acc - prod_r);
                n_state = ST_M3;
            end
            ST_M3: begin
                mul_a   = $signed({r_dm[31], r_dm});
                mul_b   = r_i;
                n_state = ST_D2;
            end
            ST_M4: begin
                mul_a   = $signed({r_mid_off[31], r_mid_off});
                mul_b   = r_i;
                n_state = ST_M4U;
            end
            ST_M4U: begin
                n_ly    = sat32(r_acc + prod_r);
                n_state = ST_CP;
            end
            ST_CP: begin
                cor_req.start = !r_wait;
                cor_req.angle = $signed({r_heading[31], r_heading})
                              - $signed({da_half[31], da_half});
                n_wait        = 1'b1;
                if (cor_rsp.done) begin
                    n_wait  = 1'b0;
                    n_s     = cor_rsp.s;
                    n_c     = cor_rsp.c;
                    n_state = ST_X1;
                end
            end
            ST_X1: begin
                mul_a   = $signed({r_c[31], r_c});
                mul_b   = $signed({r_lx[31], r_lx});
                n_state = ST_X2;
            end
            ST_X2: begin
                n_acc   = r_prod;
                mul_a   = $signed({r_s[31], r_s});
                mul_b   = $signed({r_ly[31], r_ly});
                n_state = ST_X3;
            end
            ST_X3: begin
                n_pos_x = r_pos_x + xd[31:0];
                mul_a   = $signed({r_s[31], r_s});
                mul_b   = $signed({r_lx[31], r_lx});
                n_state = ST_X4;
            end
            ST_X4: begin
                n_acc   = r_prod;
                mul_a   = $signed({r_c[31], r_c});
                mul_b   = $signed({r_ly[31], r_ly});
                n_state = ST_X5;
            end
            ST_X5: begin
                n_pos_y = r_pos_y + yd[31:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.pose_x     = r_pos_x;
                    n_out.pose_y     = r_pos_y;
                    n_out.pose_theta = r_heading;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_prod = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_prev_m    <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_prev_m    <= n_prev_m;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_in   <= n_in;
        r_dl   <= n_dl;
        r_dr   <= n_dr;
        r_dm   <= n_dm;
        r_da   <= n_da;
        r_lx   <= n_lx;
        r_ly   <= n_ly;
        r_s    <= n_s;
        r_c    <= n_c;
        r_i    <= n_i;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_qneg <= n_qneg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr_tpi  <= 31'd65536;
            r_mid_tpi <= 31'd65536;
            r_track_w <= 31'd655360;
            r_mid_off <= '0;
            r_sensor  <= 4'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LR_TPI:  r_lr_tpi  <= i_cfg_data[30:0];
                CFG_MID_TPI: r_mid_tpi <= i_cfg_data[30:0];
                CFG_TRACK_W: r_track_w <= i_cfg_data[30:0];
                CFG_MID_OFF: r_mid_off <= i_cfg_data;
                CFG_SENSOR:  r_sensor  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/two_checker.sv
// port-level checks for the odometry top level, with its bind
module two_checker import two_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // a request is worked on alone
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a request");

    // no result appears straight after a request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result too early");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind tracking_wheel_odometry_top two_checker u_two_checker (.*);
